>>> src/vhs_pkg.sv
// package for the vector hash set: sizes, status codes, fsm states, command structs
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package vhs_pkg;
    localparam int BUCKETS       = 256;
    localparam int SLOTS         = 4;
    localparam int MAX_KEY_WORDS = 8;
    localparam int BUCKET_W      = $clog2(BUCKETS);
    localparam int SLOT_W        = $clog2(SLOTS);
    localparam int WORD_W        = $clog2(MAX_KEY_WORDS);
    localparam int FILL_W        = $clog2(SLOTS + 1);
    localparam int MEM_AW        = BUCKET_W + SLOT_W + WORD_W;
    localparam logic [31:0] HASH_MULT = 32'd1997;

    localparam logic [3:0] CFG_KEY_LENGTH   = 4'd0;
    localparam logic [3:0] CFG_INDEX_OFFSET = 4'd1;

    typedef enum logic [1:0] {
        ST_ADDED   = 2'd0,
        ST_PRESENT = 2'd1,
        ST_FULL    = 2'd2,
        ST_ABSENT  = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_HASH,
        S_FILL,
        S_CMP,
        S_STORE,
        S_OUT
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic take_word;   // latch input word, update hash
        logic load_fill;   // read bucket fill count
        logic cmp_start;   // restart slot/word compare counters
        logic cmp_step;    // advance compare by one word
        logic store_step;  // write one stored word
        logic fill_bump;   // bump bucket fill count
        logic set_result;  // capture result fields
        logic clear_key;   // reset hash and position
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic key_last;    // word being taken ends the key
        logic add_op;      // pending op is add
        logic cmp_done;    // compare finished (found or exhausted)
        logic found;
        logic can_store;   // bucket not full
        logic store_last;  // last stored word written
    } dp_sts_t;
endpackage
`default_nettype wire

>>> src/vector_hash_set_insert_lookup.sv
// top level of the vector hash set: controller plus datapath
// depends on vhs_pkg, vhs_ctrl, vhs_dp
//
//  channel | ports                                               | moves
//  input   | s_valid s_ready s_func s_key_word                   | one key word per item
//  output  | m_valid m_ready m_status m_bucket_index m_slot_index | one result per key
//  config  | cfg_we cfg_index cfg_data                           | register write
//
// a non-last word only updates the hash and key buffer; the last word adds a fill read,
// a word-serial compare over the key store port, MAX_KEY_WORDS stored words for an add,
// and a result step in S_OUT.
// reset clears fill counts at once through per-bucket valid bits.
// a stalled result holds back the next key's result in S_OUT, not its words.
`timescale 1ns / 1ps
`default_nettype none
module vector_hash_set_insert_lookup import vhs_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic [3:0]  cfg_index,
    input  wire logic [9:0]  cfg_data,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic        s_func,
    input  wire logic [31:0] s_key_word,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [1:0]       m_status,
    output logic [7:0]       m_bucket_index,
    output logic [1:0]       m_slot_index
);
    dp_cmd_t cmd;
    dp_sts_t sts;

    vhs_ctrl u_ctrl (
        .aclk, .aresetn, .s_valid, .s_ready, .m_valid, .m_ready, .sts, .cmd
    );

    vhs_dp u_dp (
        .aclk, .aresetn, .cfg_we, .cfg_index, .cfg_data, .s_func, .s_key_word,
        .cmd, .sts, .m_status, .m_bucket_index, .m_slot_index
    );
endmodule
`default_nettype wire

>>> src/vhs_ctrl.sv
// controller fsm for the vector hash set
// depends on vhs_pkg
`timescale 1ns / 1ps
`default_nettype none
module vhs_ctrl import vhs_pkg::*; (
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    s_valid,
    output logic         s_ready,
    output logic         m_valid,
    input  wire logic    m_ready,
    input  wire dp_sts_t sts,
    output dp_cmd_t      cmd
);
    state_t state_reg, state_next;
    logic   mv_reg, mv_next;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            mv_reg    <= mv_next;
        end
    end

    assign m_valid = mv_reg;

    // next state and commands
    always_comb begin
        state_next = state_reg;
        mv_next    = mv_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        if (mv_reg && m_ready) mv_next = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.take_word = 1'b1;
                    if (sts.key_last) state_next = S_FILL;
                end
            end
            S_HASH: state_next = S_IDLE;
            S_FILL: begin
                cmd.load_fill = 1'b1;
                cmd.cmp_start = 1'b1;
                state_next    = S_CMP;
            end
            S_CMP: begin
                if (sts.cmp_done) begin
                    if (sts.add_op && !sts.found && sts.can_store) begin
                        cmd.cmp_start = 1'b1;
                        state_next    = S_STORE;
                    end else begin
                        state_next = S_OUT;
                    end
                end else begin
                    cmd.cmp_step = 1'b1;
                end
            end
            S_STORE: begin
                cmd.store_step = 1'b1;
                if (sts.store_last) begin
                    cmd.fill_bump = 1'b1;
                    state_next    = S_OUT;
                end
            end
            S_OUT: begin
                // wait for the output register to free up
                if (!mv_reg || m_ready) begin
                    cmd.set_result = 1'b1;
                    cmd.clear_key  = 1'b1;
                    mv_next        = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end
endmodule
`default_nettype wire

>>> src/vhs_dp.sv
// datapath: hash, key buffer, fill counts, key store, compare, result registers
// depends on vhs_pkg
`timescale 1ns / 1ps
`default_nettype none
module vhs_dp import vhs_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic [3:0]  cfg_index,
    input  wire logic [9:0]  cfg_data,
    input  wire logic        s_func,
    input  wire logic [31:0] s_key_word,
    input  wire dp_cmd_t     cmd,
    output dp_sts_t          sts,
    output logic [1:0]       m_status,
    output logic [7:0]       m_bucket_index,
    output logic [1:0]       m_slot_index
);
    logic [3:0]          klen_reg;
    logic [9:0]          ofs_reg;
    logic [31:0]         hash_reg;
    logic [WORD_W-1:0]   pos_reg;
    logic                op_reg;
    logic [31:0]         key_reg [MAX_KEY_WORDS];
    logic [FILL_W-1:0]   fill_mem [BUCKETS];
    logic [31:0]         store_mem [2**MEM_AW];
    logic [FILL_W-1:0]   fill_reg;
    logic [SLOT_W:0]     slot_reg;
    logic [WORD_W:0]     widx_reg;
    logic                rd_ok_reg;
    logic                mism_reg;
    logic                found_reg;
    logic [SLOT_W-1:0]   fslot_reg;
    logic [31:0]         rdata_reg;
    logic [WORD_W-1:0]   rword_reg;
    logic [1:0]          status_reg;
    logic [7:0]          bucket_reg;
    logic [1:0]          slotout_reg;
    logic [WORD_W:0]     len;
    logic [31:0]         prod, hash_next;
    logic [BUCKET_W-1:0] bucket;

    // effective key length, clamped to 1..MAX_KEY_WORDS
    always_comb begin
        if (klen_reg == 4'd0) len = (WORD_W+1)'(1);
        else if (32'(klen_reg) > MAX_KEY_WORDS) len = (WORD_W+1)'(MAX_KEY_WORDS);
        else len = (WORD_W+1)'(klen_reg);
    end

    assign prod      = (32'(ofs_reg) + 32'(pos_reg)) * s_key_word;
    assign hash_next = hash_reg * HASH_MULT + prod;
    assign bucket    = hash_reg[BUCKET_W-1:0];
    assign sts.key_last = (32'(pos_reg) + 1) >= 32'(len);
    assign sts.add_op   = op_reg;
    assign sts.found    = found_reg;
    assign sts.can_store = 32'(fill_reg) < SLOTS;
    // done once a match is seen, or all slots are read and the last check is through
    assign sts.cmp_done = found_reg || ((32'(slot_reg) >= 32'(fill_reg)) && !rd_ok_reg);
    assign sts.store_last = (32'(widx_reg) == MAX_KEY_WORDS - 1);

    // config registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            klen_reg <= 4'd8;
            ofs_reg  <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_KEY_LENGTH:   klen_reg <= cfg_data[3:0];
                CFG_INDEX_OFFSET: ofs_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // hash and word position
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hash_reg <= '0;
            pos_reg  <= '0;
            op_reg   <= 1'b0;
        end else if (cmd.take_word) begin
            hash_reg <= hash_next;
            if (pos_reg == '0) op_reg <= s_func;
            if (!sts.key_last) pos_reg <= pos_reg + 1'b1;
        end else if (cmd.clear_key) begin
            hash_reg <= '0;
            pos_reg  <= '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.take_word) key_reg[pos_reg] <= s_key_word;
    end

    // fill counts, cleared by valid bits at reset
    logic [BUCKETS-1:0] fvalid_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) fvalid_reg <= '0;
        else if (cmd.fill_bump) fvalid_reg[bucket] <= 1'b1;
    end
    always_ff @(posedge aclk) begin
        if (cmd.fill_bump) fill_mem[bucket] <= fill_reg + 1'b1;
        if (cmd.load_fill) fill_reg <= fvalid_reg[bucket] ? fill_mem[bucket] : '0;
    end

    // compare: one stored word read per cycle, checked the cycle after
    logic [MEM_AW-1:0] raddr;
    logic              wlast;
    logic              issue;
    logic [SLOT_W:0]   cslot_reg;
    logic              clast_reg;
    logic              mis_now;
    assign raddr   = {bucket, slot_reg[SLOT_W-1:0], widx_reg[WORD_W-1:0]};
    assign wlast   = (32'(widx_reg) + 1) >= 32'(len);
    assign issue   = cmd.cmp_step && (32'(slot_reg) < 32'(fill_reg));
    assign mis_now = mism_reg || (rdata_reg != key_reg[rword_reg]);

    // read side: stored word, its position and whether it ends the slot
    always_ff @(posedge aclk) begin
        if (issue) begin
            rdata_reg <= store_mem[raddr];
            rword_reg <= widx_reg[WORD_W-1:0];
            cslot_reg <= slot_reg;
            clast_reg <= wlast;
        end
    end

    // slot/word counters and match tracking
    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.cmp_start) begin
            found_reg <= 1'b0;
            rd_ok_reg <= 1'b0;
            mism_reg  <= 1'b0;
            slot_reg  <= '0;
            widx_reg  <= '0;
        end else begin
            rd_ok_reg <= issue;
            if (issue) begin
                if (wlast) begin
                    widx_reg <= '0;
                    slot_reg <= slot_reg + 1'b1;
                end else begin
                    widx_reg <= widx_reg + 1'b1;
                end
            end else if (cmd.store_step) begin
                widx_reg <= widx_reg + 1'b1;
            end
            // check the word read last cycle
            if (rd_ok_reg && !found_reg) begin
                if (clast_reg) begin
                    mism_reg <= 1'b0;
                    if (!mis_now) begin
                        found_reg <= 1'b1;
                        fslot_reg <= cslot_reg[SLOT_W-1:0];
                    end
                end else begin
                    mism_reg <= mis_now;
                end
            end
        end
    end

    // stored keys memory write
    always_ff @(posedge aclk) begin
        if (cmd.store_step)
            store_mem[{bucket, fill_reg[SLOT_W-1:0], widx_reg[WORD_W-1:0]}] <=
                (32'(widx_reg) < 32'(len)) ? key_reg[widx_reg[WORD_W-1:0]] : 32'd0;
    end

    // result registers
    always_ff @(posedge aclk) begin
        if (cmd.set_result) begin
            bucket_reg <= 8'(bucket);
            if (found_reg) begin
                status_reg  <= ST_PRESENT;
                slotout_reg <= 2'(fslot_reg);
            end else if (!op_reg) begin
                status_reg  <= ST_ABSENT;
                slotout_reg <= '0;
            end else if (!sts.can_store) begin
                status_reg  <= ST_FULL;
                slotout_reg <= '0;
            end else begin
                status_reg  <= ST_ADDED;
                slotout_reg <= 2'(fill_reg);
            end
        end
    end

    assign m_status       = status_reg;
    assign m_bucket_index = bucket_reg;
    assign m_slot_index   = slotout_reg;
endmodule
`default_nettype wire

>>> src/vhs_checker.sv
// port-level checker for the vector hash set, bound to the top level
// depends on vhs_pkg and vector_hash_set_insert_lookup
`timescale 1ns / 1ps
`default_nettype none
module vhs_checker import vhs_pkg::*; (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       s_valid,
    input wire logic       s_ready,
    input wire logic       m_valid,
    input wire logic       m_ready,
    input wire logic [1:0] m_status,
    input wire logic [7:0] m_bucket_index,
    input wire logic [1:0] m_slot_index
);
    // result held while stalled
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_bucket_index)
                                && $stable(m_slot_index))
        else $error("result changed under stall");
    // no result right after reset
    a_rst: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result after reset");
    // full and absent carry slot zero
    a_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == ST_FULL || m_status == ST_ABSENT) |-> m_slot_index == 2'd0)
        else $error("nonzero slot");
endmodule

bind vector_hash_set_insert_lookup vhs_checker u_chk (
    .aclk, .aresetn, .s_valid, .s_ready, .m_valid, .m_ready,
    .m_status, .m_bucket_index, .m_slot_index
);
`default_nettype wire

>>> tb/sv/vhs_result_checker.sv
// result checker for the vector hash set: watches both channels, predicts and compares
// depends on vhs_pkg; the testbench top mirrors register writes into it
`timescale 1ns / 1ps
`default_nettype none
module vhs_result_checker import vhs_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic [3:0]  cfg_index,
    input  wire logic [9:0]  cfg_data,
    input  wire logic        s_valid,
    input  wire logic        s_ready,
    input  wire logic        s_func,
    input  wire logic [31:0] s_key_word,
    input  wire logic        m_valid,
    input  wire logic        m_ready,
    input  wire logic [1:0]  m_status,
    input  wire logic [7:0]  m_bucket_index,
    input  wire logic [1:0]  m_slot_index,
    output int               fail_count,
    output int               pending_results
);
    typedef struct packed {
        status_t    status;
        logic [7:0] bucket;
        logic [1:0] slot;
    } set_result_t;

    // predicted copy of the set
    logic [3:0]  key_len_reg;
    logic [9:0]  offset_reg;
    logic [31:0] hash_acc;
    int          word_pos;
    logic        op_is_add;
    logic [31:0] key_buf [MAX_KEY_WORDS];
    int          fill_cnt [BUCKETS];
    logic [31:0] key_store [BUCKETS][SLOTS][MAX_KEY_WORDS];
    set_result_t expected_results [$];

    assign pending_results = expected_results.size();

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t: %s got %0d want %0d", $realtime, what, got, want);
        fail_count++;
    endtask

    // fold one word into the key and predict the outcome on the last word
    task automatic absorb_key_word(input logic func, input logic [31:0] word);
        int          len;
        int          pos;
        int          bkt;
        int          fill;
        int          hit;
        bit          same;
        set_result_t res;
        len = (key_len_reg == 0) ? 1 : (key_len_reg > MAX_KEY_WORDS) ? MAX_KEY_WORDS
                                                                     : key_len_reg;
        pos = (word_pos >= MAX_KEY_WORDS) ? MAX_KEY_WORDS - 1 : word_pos;
        if (pos == 0) op_is_add = func;
        key_buf[pos] = word;
        hash_acc = hash_acc * 32'd1997 + (32'(offset_reg) + 32'(pos)) * word;
        if (pos + 1 < len) begin
            word_pos = pos + 1;
            return;
        end
        bkt = hash_acc[7:0];
        fill = fill_cnt[bkt];
        hit = -1;
        for (int s = 0; s < fill && hit < 0; s++) begin
            same = 1;
            for (int w = 0; w < len; w++)
                if (key_store[bkt][s][w] != key_buf[w]) same = 0;
            if (same) hit = s;
        end
        res.bucket = bkt[7:0];
        res.slot = 2'd0;
        if (hit >= 0) begin
            res.status = ST_PRESENT;
            res.slot = hit[1:0];
        end else if (!op_is_add) begin
            res.status = ST_ABSENT;
        end else if (fill >= SLOTS) begin
            res.status = ST_FULL;
        end else begin
            for (int w = 0; w < MAX_KEY_WORDS; w++)
                key_store[bkt][fill][w] = (w < len) ? key_buf[w] : 32'd0;
            fill_cnt[bkt] = fill + 1;
            res.status = ST_ADDED;
            res.slot = fill[1:0];
        end
        expected_results.push_back(res);
        hash_acc = 0;
        word_pos = 0;
    endtask

    initial begin
        fail_count = 0;
    end

    // predict on accepted input items, compare accepted results
    always @(posedge aclk) begin
        if (!aresetn) begin
            key_len_reg <= 4'd8;
            offset_reg <= 10'd0;
            hash_acc = 0;
            word_pos = 0;
            op_is_add = 0;
            for (int b = 0; b < BUCKETS; b++) fill_cnt[b] = 0;
            expected_results.delete();
        end else begin
            if (cfg_we && cfg_index == CFG_KEY_LENGTH) key_len_reg <= cfg_data[3:0];
            if (cfg_we && cfg_index == CFG_INDEX_OFFSET) offset_reg <= cfg_data;
            if (s_valid && s_ready) absorb_key_word(s_func, s_key_word);
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected result, status", m_status, 0);
                end else begin
                    set_result_t want;
                    want = expected_results.pop_front();
                    if (m_status !== want.status)
                        report_mismatch("status", m_status, want.status);
                    if (m_bucket_index !== want.bucket)
                        report_mismatch("bucket_index", m_bucket_index, want.bucket);
                    if (m_slot_index !== want.slot)
                        report_mismatch("slot_index", m_slot_index, want.slot);
                end
            end
        end
    end
endmodule
`default_nettype wire

>>> tb/sv/tb_vector_hash_set_insert_lookup.sv
// testbench top for the vector hash set: clock, reset, stimulus and verdict
// depends on vhs_pkg, vector_hash_set_insert_lookup, vhs_result_checker
`timescale 1ns / 1ps
`default_nettype none
module tb_vector_hash_set_insert_lookup;
    import vhs_pkg::*;

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        cfg_we = 0;
    logic [3:0]  cfg_index = CFG_KEY_LENGTH;
    logic [9:0]  cfg_data = 0;
    logic        s_valid = 0;
    logic        s_ready;
    logic        s_func = 0;
    logic [31:0] s_key_word = 0;
    logic        m_valid;
    logic        m_ready = 0;
    logic [1:0]  m_status;
    logic [7:0]  m_bucket_index;
    logic [1:0]  m_slot_index;
    int          fail_count;
    int          pending_results;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          cur_key_len = 8;

    // pool of recently sent keys, replayed to hit present and full cases
    logic [31:0] key_pool [64][MAX_KEY_WORDS];
    int          pool_count = 0;

    always #5 aclk = ~aclk;

    vector_hash_set_insert_lookup u_top (.*);

    vhs_result_checker u_check (.*);

    // receiver stalls at random
    always @(negedge aclk)
        m_ready <= ($urandom_range(99) >= recv_idle_pct);

    // valid stays up after acceptance until the next call or an explicit drop
    task automatic send_word(input logic func, input logic [31:0] word);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 0;
            @(negedge aclk);
        end
        s_valid <= 1;
        s_func <= func;
        s_key_word <= word;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic send_key(input logic func, input logic [31:0] words [MAX_KEY_WORDS]);
        int n;
        n = (cur_key_len == 0) ? 1 : (cur_key_len > MAX_KEY_WORDS) ? MAX_KEY_WORDS
                                                                   : cur_key_len;
        for (int w = 0; w < n; w++) send_word(w == 0 ? func : ~func, words[w]);
        if (pool_count < 64) begin
            key_pool[pool_count] = words;
            pool_count++;
        end else begin
            int k;
            k = $urandom_range(63);
            key_pool[k] = words;
        end
    endtask

    // only while idle: wait for results, let the block settle, then write
    task automatic write_reg(input logic [3:0] idx, input logic [9:0] value);
        s_valid <= 0;
        while (pending_results != 0) @(negedge aclk);
        repeat (50) @(negedge aclk);
        cfg_we <= 1;
        cfg_index <= idx;
        cfg_data <= value;
        @(negedge aclk);
        cfg_we <= 0;
        if (idx == CFG_KEY_LENGTH) cur_key_len = value[3:0];
    endtask

    function automatic logic [31:0] rand_word();
        case ($urandom_range(5))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'hffff_ffff;
            3: return 32'd0;
            4: return 32'($urandom_range(3));
            default: return $urandom;
        endcase
    endfunction

    task automatic random_keys(input int count);
        logic [31:0] words [MAX_KEY_WORDS];
        int          r;
        for (int i = 0; i < count; i++) begin
            for (int w = 0; w < MAX_KEY_WORDS; w++) words[w] = rand_word();
            r = $urandom_range(9);
            // replay an old key, reusing it under the current length
            if (r < 4 && pool_count > 0)
                words = key_pool[$urandom_range(pool_count - 1)];
            send_key(r < 6, words);
        end
    endtask

    initial begin
        logic [31:0] words [MAX_KEY_WORDS];
        repeat (8) @(negedge aclk);
        aresetn <= 1;
        @(negedge aclk);

        // directed: reset length, extremes, duplicates, finds, full bucket
        for (int w = 0; w < MAX_KEY_WORDS; w++) words[w] = 32'h8000_0000;
        send_key(0, words);
        send_key(1, words);
        send_key(1, words);
        send_key(0, words);
        for (int w = 0; w < MAX_KEY_WORDS; w++) words[w] = 32'h7fff_ffff;
        send_key(1, words);
        write_reg(CFG_KEY_LENGTH, 10'd1);
        write_reg(CFG_INDEX_OFFSET, 10'd0);
        // offset zero with one word: hash is zero, so all fill bucket 0
        for (int i = 0; i < 6; i++) begin
            words[0] = 32'(i) ^ 32'hffff_ffff;
            send_key(1, words);
        end
        send_key(0, words);
        write_reg(CFG_KEY_LENGTH, 10'd0);
        send_key(0, words);
        write_reg(CFG_KEY_LENGTH, 10'd15);
        write_reg(CFG_INDEX_OFFSET, 10'd1023);
        send_key(1, words);

        // random phases over several settings and idling patterns
        for (int ph = 0; ph < 9; ph++) begin
            send_idle_pct = (ph < 3) ? 37 : (ph < 6) ? 87 : 0;
            recv_idle_pct = (ph < 3) ? 87 : (ph < 6) ? 37 : 0;
            write_reg(CFG_KEY_LENGTH, 10'($urandom_range(ph % 3 == 0 ? 8 : 3)));
            write_reg(CFG_INDEX_OFFSET,
                      (ph == 4) ? 10'd1023 : 10'($urandom_range(1023)));
            random_keys(45);
        end
        // a mid-key length change, taken only while the set is idle
        write_reg(CFG_KEY_LENGTH, 10'd4);
        send_word(1, $urandom);
        send_word(0, $urandom);
        write_reg(CFG_KEY_LENGTH, 10'd2);
        send_word(1, $urandom);

        s_valid <= 0;
        while (pending_results != 0) @(negedge aclk);
        repeat (60) @(negedge aclk);
        if (fail_count == 0 && pending_results == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial begin
        #5ms;
        $display("Mismatches found");
        $finish;
    end
endmodule
`default_nettype wire
